// ===== sv/skpq_pkg.sv =====
// Package for the sorted-key priority queue: operation and status codes,
// and the control struct that the top level broadcasts to every cell.
// No dependencies.
package skpq_pkg;

   localparam int KEY_W    = 64;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd4;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef enum logic {
      S_IDLE,
      S_APPLY
   } state_type;

   typedef struct packed {
      logic              apply;
      logic [KIND_W-1:0] kind;
      logic              hit;
      logic              full;
      key_type           key;
   } bcast_type;

endpackage

// ===== sv/skpq_if.sv =====
// Valid/ready channel interfaces for the request and response transactions.
// Depends on skpq_pkg.
interface skpq_req_if
   import skpq_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   key_type           key;

   modport source (output valid, kind, key, input ready);
   modport sink   (input valid, kind, key, output ready);
endinterface

interface skpq_rsp_if
   import skpq_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   key_type             popped_key;

   modport source (output valid, status, popped_key, input ready);
   modport sink   (input valid, status, popped_key, output ready);
endinterface

// ===== sv/skpq_cell.sv =====
// One storage cell of the sorted chain: key, occupancy, compare flags.
// Shifts with its neighbors on insert, remove and pop. Depends on skpq_pkg.
module skpq_cell
   import skpq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      cmp_en,
   input  key_type   cmp_key,
   input  bcast_type bcast,
   input  key_type   left_key,
   input  logic      left_occ,
   input  logic      left_lt,
   input  key_type   right_key,
   input  logic      right_occ,
   output key_type   key,
   output logic      occ,
   output logic      lt,
   output logic      eq
);

   key_type key_ff, key_in;
   logic    occ_ff, occ_in;
   logic    lt_ff, lt_in;
   logic    eq_ff, eq_in;

   always_comb begin
      key_in = key_ff;
      occ_in = occ_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      if (cmp_en) begin
         lt_in = occ_ff && (key_ff < cmp_key);
         eq_in = occ_ff && (key_ff == cmp_key);
      end
      if (bcast.apply) begin
         case (bcast.kind)
            KIND_INSERT: begin
               if (!bcast.hit && !bcast.full && !lt_ff) begin
                  if (left_lt) begin
                     key_in = bcast.key;
                     occ_in = 1'b1;
                  end else begin
                     key_in = left_key;
                     occ_in = left_occ;
                  end
               end
            end
            KIND_REMOVE: begin
               if (bcast.hit && !lt_ff) begin
                  key_in = right_key;
                  occ_in = right_occ;
               end
            end
            KIND_POP: begin
               key_in = right_key;
               occ_in = right_occ;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign key = key_ff;
   assign occ = occ_ff;
   assign lt  = lt_ff;
   assign eq  = eq_ff;

endmodule

// ===== sv/sorted_key_priority_queue.sv =====
// Sorted-key priority queue: a chain of CAPACITY cells keeps unique signed keys in
// ascending order, occupied cells packed from cell 0. In the accept cycle every cell
// compares its key with the request key; in S_APPLY, once the response slot is free,
// the cells shift one place toward or away from the insertion point and the response
// is registered. A response that waits holds the next transaction in S_APPLY. No
// clearing pass; the queue is empty right after reset.
module sorted_key_priority_queue
   import skpq_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   skpq_req_if.sink    req_chan,
   skpq_rsp_if.source  rsp_chan
);

   state_type           state_ff, state_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   key_type             key_ff, key_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   key_type             popped_ff, popped_in;

   key_type            cell_key [CAPACITY];
   logic [CAPACITY-1:0] cell_occ, cell_lt, cell_eq;
   bcast_type           bcast;
   logic                accept, slot_free, hit, full, empty;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign hit       = |cell_eq;
   assign full      = cell_occ[CAPACITY-1];
   assign empty     = !cell_occ[0];

   assign bcast.apply = (state_ff == S_APPLY) && slot_free;
   assign bcast.kind  = kind_ff;
   assign bcast.hit   = hit;
   assign bcast.full  = full;
   assign bcast.key   = key_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type lk, rk;
      logic    lo, llt, ro;
      if (i == 0) begin : g_first
         assign lk  = '0;
         assign lo  = 1'b0;
         assign llt = 1'b1;
      end else begin : g_mid
         assign lk  = cell_key[i-1];
         assign lo  = cell_occ[i-1];
         assign llt = cell_lt[i-1];
      end
      if (i == CAPACITY-1) begin : g_last
         assign rk = '0;
         assign ro = 1'b0;
      end else begin : g_inner
         assign rk = cell_key[i+1];
         assign ro = cell_occ[i+1];
      end
      skpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmp_en    (accept),
         .cmp_key   (req_chan.key),
         .bcast     (bcast),
         .left_key  (lk),
         .left_occ  (lo),
         .left_lt   (llt),
         .right_key (rk),
         .right_occ (ro),
         .key       (cell_key[i]),
         .occ       (cell_occ[i]),
         .lt        (cell_lt[i]),
         .eq        (cell_eq[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      popped_in    = popped_ff;
      req_chan.ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in  = req_chan.kind;
               key_in   = req_chan.key;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               popped_in    = '0;
               status_in    = ST_DONE;
               case (kind_ff)
                  KIND_INSERT: begin
                     if (hit) begin
                        status_in = ST_DUP;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!hit) begin
                        status_in = ST_ABSENT;
                     end
                  end
                  KIND_POP: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        popped_in = cell_key[0];
                     end
                  end
                  default: ;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      popped_ff <= popped_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.popped_key = popped_ff;

endmodule

// ===== sv/skpq_checker.sv =====
// Port-level checks for the sorted-key priority queue, bound to the top level.
// Depends on skpq_pkg.
module skpq_port_checks
   import skpq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input key_type             rsp_popped_key
);

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_popped_key))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_DONE || rsp_status == ST_DUP
         || rsp_status == ST_ABSENT || rsp_status == ST_EMPTY || rsp_status == ST_FULL)
      else $error("undefined status code");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_popped_key == '0)
      else $error("popped key set on a failed transaction");

endmodule

bind sorted_key_priority_queue skpq_port_checks u_skpq_port_checks (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_popped_key (rsp_chan.popped_key)
);
